>>> rtl/core/ycod_pkg.sv
// Shared types, constants and the step scale table of the ADPCM codec.
package ycod_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_PASS = 2'd1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  localparam logic [14:0] STEP_RESET = 15'd127;
  localparam logic [16:0] STEP_MIN = 17'd127;
  localparam logic [16:0] STEP_MAX = 17'd24576;
  localparam logic [14:0] DIFF_MAX = 15'd32767;

  typedef struct packed {
    logic        dec;
    logic [15:0] data;
    logic        last;
    logic        bend;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAK,
    ST_DIV,
    ST_MUL,
    ST_APPLY
  } state_t;

  function automatic logic [9:0] step_scale(input logic [2:0] d);
    logic [9:0] s;
    unique case (d)
      3'd0, 3'd1, 3'd2, 3'd3: s = 10'd230;
      3'd4: s = 10'd307;
      3'd5: s = 10'd409;
      3'd6: s = 10'd512;
      default: s = 10'd614;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/ycod_front.sv
// Front end: accepts input words and splits them into per-code queue entries.
module ycod_front import ycod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample_in,
  input  logic [7:0]  byte_in,
  input  logic        block_end,
  output logic        push_valid,
  input  logic        push_ready,
  output entry_t      push_entry
);

  logic   hold;
  entry_t hold_entry;
  logic   accept;

  assign in_ready = !hold && push_ready;
  assign accept = in_valid && in_ready;
  assign push_valid = hold || in_valid;

  always_comb begin
    if (hold) begin
      push_entry = hold_entry;
    end else if (mode == MODE_DECODE) begin
      push_entry.dec = 1'b1;
      push_entry.data = {12'd0, byte_in[3:0]};
      push_entry.last = 1'b0;
      push_entry.bend = 1'b0;
    end else begin
      push_entry.dec = 1'b0;
      push_entry.data = sample_in;
      push_entry.last = 1'b1;
      push_entry.bend = block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (hold && push_ready) begin
      hold <= 1'b0;
    end else if (accept && mode == MODE_DECODE) begin
      hold <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_entry.dec <= 1'b1;
      hold_entry.data <= {12'd0, byte_in[7:4]};
      hold_entry.last <= 1'b1;
      hold_entry.bend <= block_end;
    end
  end

endmodule

>>> rtl/core/ycod_queue.sv
// Two-entry queue that decouples the front end from the codec core.
module ycod_queue import ycod_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop,
  output entry_t pop_entry
);

  entry_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && pop_valid;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ycod_core.sv
// Codec core: quantizes, updates prediction and step size, and holds the result word.
module ycod_core import ycod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        high_pass,
  input  logic        q_valid,
  output logic        q_pop,
  input  entry_t      q_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sample_out,
  output logic [7:0]  code_byte,
  output logic        kind,
  output logic        last,
  output logic        block_end_out
);

  state_t      state;
  state_t      state_next;
  logic [15:0] pred;
  logic [14:0] step;
  logic        phase;
  logic [3:0]  pending;
  logic [3:0]  code;
  logic        neg;
  logic [17:0] rem;
  logic [3:0]  quo;
  logic [1:0]  cnt;
  logic        is_dec;
  logic        ent_last;
  logic        ent_bend;
  logic [18:0] prod_diff;
  logic [24:0] prod_step;

  logic        emit;
  logic        out_free;
  logic        advance;
  logic [15:0] s_masked;
  logic [16:0] err;
  logic [16:0] err_abs;
  logic [17:0] divisor;
  logic [3:0]  cur_code;
  logic [23:0] leak_prod;
  logic [23:0] leak_adj;
  logic [15:0] diff_raw;
  logic [14:0] diff;
  logic [16:0] psum;
  logic [15:0] pred_new;
  logic [16:0] nstep_raw;
  logic [14:0] nstep;

  assign out_free = !out_valid || out_ready;
  assign emit = is_dec || phase;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (!q_entry.dec) begin
            state_next = ST_DIV;
          end else if (high_pass) begin
            state_next = ST_LEAK;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_LEAK: state_next = ST_MUL;
      ST_DIV: begin
        if (cnt == 2'd0) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_APPLY;
      ST_APPLY: begin
        if (!emit || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == ST_IDLE) && q_valid;
    advance = (state == ST_APPLY) && (!emit || out_free);
  end

  assign s_masked = {q_entry.data[15:3], 3'b000};
  assign err = {s_masked[15], s_masked} - {pred[15], pred};
  assign err_abs = err[16] ? (17'd0 - err) : err;
  assign divisor = {3'd0, step} << cnt;
  assign cur_code = is_dec ? code : {neg, (quo[3] ? 3'd7 : quo[2:0])};

  assign leak_prod = {pred, 8'd0} - {{7{pred[15]}}, pred, 1'b0};
  assign leak_adj = leak_prod + (leak_prod[23] ? 24'd255 : 24'd0);

  assign diff_raw = prod_diff[18:3];
  assign diff = diff_raw[15] ? DIFF_MAX : diff_raw[14:0];
  assign psum = code[3] ? ({pred[15], pred} - {2'd0, diff})
                        : ({pred[15], pred} + {2'd0, diff});

  always_comb begin
    if (!psum[16] && psum[15]) begin
      pred_new = 16'h7fff;
    end else if (psum[16] && !psum[15]) begin
      pred_new = 16'h8000;
    end else begin
      pred_new = psum[15:0];
    end
  end

  assign nstep_raw = prod_step[24:8];

  always_comb begin
    if (nstep_raw < STEP_MIN) begin
      nstep = STEP_MIN[14:0];
    end else if (nstep_raw > STEP_MAX) begin
      nstep = STEP_MAX[14:0];
    end else begin
      nstep = nstep_raw[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pred <= '0;
      step <= STEP_RESET;
      phase <= 1'b0;
      pending <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LEAK) begin
        pred <= leak_adj[23:8];
      end
      if (advance) begin
        pred <= pred_new;
        step <= nstep;
        if (!is_dec) begin
          phase <= !phase;
          if (!phase) begin
            pending <= code;
          end
        end
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      is_dec <= q_entry.dec;
      ent_last <= q_entry.last;
      ent_bend <= q_entry.bend;
      code <= q_entry.data[3:0];
      rem <= {err_abs[15:0], 2'b00};
      neg <= err[16];
      quo <= '0;
      cnt <= 2'd3;
    end
    if (state == ST_DIV) begin
      if (rem >= divisor) begin
        rem <= rem - divisor;
        quo[cnt] <= 1'b1;
      end
      cnt <= cnt - 2'd1;
    end
    if (state == ST_MUL) begin
      code <= cur_code;
      prod_diff <= {15'd0, cur_code[2:0], 1'b1} * {4'd0, step};
      prod_step <= {15'd0, step_scale(cur_code[2:0])} * {10'd0, step};
    end
    if (advance && emit) begin
      if (is_dec) begin
        sample_out <= pred_new;
        code_byte <= '0;
        kind <= KIND_SAMPLE;
        last <= ent_last;
        block_end_out <= ent_last && ent_bend;
      end else begin
        sample_out <= '0;
        code_byte <= {code, pending};
        kind <= KIND_BYTE;
        last <= 1'b1;
        block_end_out <= ent_bend;
      end
    end
  end

endmodule

>>> rtl/core/yamaha_adpcm_codec.sv
// Top level of the 4-bit ADPCM codec: configuration registers, front end, queue and core.
//
// In encode mode every sample passes through the core in steps (one to form
// the error, four restoring-divide steps for the quantizer, one multiply, one
// update), and every second sample yields one packed code word. In decode mode
// each byte yields two sample words; each code takes a multiply and an update,
// preceded by a leak step when the leak is enabled. The core handles one code
// at a time; a two-entry queue lets the input side run ahead of it, and the
// output register lets the core finish its next code while a result word
// waits to be taken. Configuration writes are accepted in every cycle and
// must only be issued while no word is in flight.
module yamaha_adpcm_codec import ycod_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     sample_in,
  input  logic [7:0]             byte_in,
  input  logic                   block_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     sample_out,
  output logic [7:0]             code_byte,
  output logic                   kind,
  output logic                   last,
  output logic                   block_end_out
);

  logic   mode;
  logic   high_pass;
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;
  logic [15:0] sample_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      high_pass <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) begin
        mode <= cfg_data;
      end else if (cfg_index == CFG_HIGH_PASS) begin
        high_pass <= cfg_data;
      end
    end
  end

  ycod_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .byte_in    (byte_in),
    .block_end  (block_end),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ycod_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  ycod_core u_core (
    .clk           (clk),
    .rst           (rst),
    .high_pass     (high_pass),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_entry       (q_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_word),
    .code_byte     (code_byte),
    .kind          (kind),
    .last          (last),
    .block_end_out (block_end_out)
  );

  assign sample_out = sample_word;

endmodule
